// ===== rtl/core/cec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cec_pkg
// Types, constants and small tables for the calendar / epoch converter.
// ----------------------------------------------------------------------------
package cec_pkg;

  localparam logic OP_CAL_TO_MS   = 1'b0;
  localparam logic OP_SEC_TO_CAL  = 1'b1;

  localparam logic [11:0] EPOCH_YEAR = 12'd1970;
  localparam logic [11:0] BASE_YEAR  = 12'd2000;
  // 1970 modulo 400
  localparam logic [8:0]  EPOCH_M400 = 9'd370;
  localparam logic [8:0]  M400_LAST  = 9'd399;
  localparam logic [11:0] LAST_YEAR  = 12'd2106;

  localparam logic [31:0] SEC_PER_DAY  = 32'd86400;
  localparam logic [31:0] MS_PER_SEC   = 32'd1000;
  localparam logic [31:0] SIXTY        = 32'd60;
  localparam logic [31:0] TWENTY_FOUR  = 32'd24;

  // reciprocal constants for exact 32-bit unsigned division
  localparam logic [31:0] MAGIC_DIV60  = 32'h8888_8889;
  localparam int          SHIFT_DIV60  = 37;
  localparam logic [31:0] MAGIC_DIV24  = 32'hAAAA_AAAB;
  localparam int          SHIFT_DIV24  = 36;

  localparam logic [1:0] DIV_SEC  = 2'd0;
  localparam logic [1:0] DIV_MIN  = 2'd1;
  localparam logic [1:0] DIV_HOUR = 2'd2;

  localparam logic [3:0] MONTH_FEB_IDX = 4'd1;
  localparam logic [3:0] MONTH_COUNT   = 4'd12;

  localparam int MAC_W = 66;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_YEAR0,
    ST_MONTH0,
    ST_HM,
    ST_HMS,
    ST_SEC,
    ST_MS,
    ST_DIVQ,
    ST_DIVR,
    ST_YEAR1,
    ST_MONTH1,
    ST_DONE
  } cec_state_t;

  // operands of the shared multiply-accumulate unit: y = c +/- a * b
  typedef struct packed {
    logic [33:0] a;
    logic [31:0] b;
    logic [43:0] c;
    logic        sub;
  } mac_op_t;

  // leap rule from the year modulo 400
  function automatic logic leap_f(input logic [8:0] m400);
    leap_f = (m400[1:0] == 2'b00) && (m400 != 9'd100) && (m400 != 9'd200) &&
             (m400 != 9'd300);
  endfunction

  // days before month, zero-based month index
  function automatic logic [8:0] days_before_f(input logic [3:0] idx);
    case (idx)
      4'd0:    days_before_f = 9'd0;
      4'd1:    days_before_f = 9'd31;
      4'd2:    days_before_f = 9'd59;
      4'd3:    days_before_f = 9'd90;
      4'd4:    days_before_f = 9'd120;
      4'd5:    days_before_f = 9'd151;
      4'd6:    days_before_f = 9'd181;
      4'd7:    days_before_f = 9'd212;
      4'd8:    days_before_f = 9'd243;
      4'd9:    days_before_f = 9'd273;
      4'd10:   days_before_f = 9'd304;
      4'd11:   days_before_f = 9'd334;
      default: days_before_f = 9'd0;
    endcase
  endfunction

  // month length in a common year, zero-based month index
  function automatic logic [4:0] month_len_f(input logic [3:0] idx);
    case (idx)
      4'd1:                      month_len_f = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   month_len_f = 5'd30;
      default:                   month_len_f = 5'd31;
    endcase
  endfunction

endpackage

// ===== rtl/core/cec_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cec_if
// Valid/ready channels carrying converter requests and results.
// ----------------------------------------------------------------------------
interface cec_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] epoch_seconds;
  logic [7:0]  year_in;
  logic [3:0]  month_in;
  logic [4:0]  day_in;
  logic [4:0]  hours_in;
  logic [5:0]  minutes_in;
  logic [5:0]  seconds_in;

  modport source (
    output valid, opcode, epoch_seconds, year_in, month_in, day_in, hours_in,
           minutes_in, seconds_in,
    input  ready
  );
  modport sink (
    input  valid, opcode, epoch_seconds, year_in, month_in, day_in, hours_in,
           minutes_in, seconds_in,
    output ready
  );
endinterface

interface cec_out_if;
  logic        valid;
  logic        ready;
  logic [43:0] epoch_ms;
  logic [7:0]  year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [4:0]  hours_out;
  logic [5:0]  minutes_out;
  logic [5:0]  seconds_out;

  modport source (
    output valid, epoch_ms, year_out, month_out, day_out, hours_out,
           minutes_out, seconds_out,
    input  ready
  );
  modport sink (
    input  valid, epoch_ms, year_out, month_out, day_out, hours_out,
           minutes_out, seconds_out,
    output ready
  );
endinterface

// ===== rtl/core/cec_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cec_mac
// Shared multiply-accumulate unit: y = c + a * b, or c - a * b.
// ----------------------------------------------------------------------------
module cec_mac import cec_pkg::*; (
  input  mac_op_t          op,
  output logic [MAC_W-1:0] y
);

  logic [MAC_W-1:0] prod;
  logic [MAC_W-1:0] addend;

  assign prod   = op.a * op.b;
  assign addend = {{(MAC_W-44){1'b0}}, op.c};
  assign y      = op.sub ? (addend - prod) : (addend + prod);

endmodule

// ===== rtl/core/calendar_epoch_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_epoch_converter
// Converts between calendar time and Unix epoch time, one request at a time.
// ----------------------------------------------------------------------------
// One request is worked at a time by a small sequencer around a single
// multiply-accumulate unit. Calendar to milliseconds makes one pass per year
// since 1970, then five arithmetic steps. Seconds to calendar makes a quotient
// and a remainder step for each of seconds, minutes and hours, then one pass
// per elapsed year and per elapsed month. The result waits in an output
// register; a new request is taken once that register is free or being
// emptied. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module calendar_epoch_converter import cec_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  cec_in_if.sink     in_if,
  cec_out_if.source  out_if
);

  cec_state_t  state_r, state_nxt;
  logic        op_r, op_nxt;
  logic [11:0] year_r, year_nxt;
  logic [11:0] tgt_r, tgt_nxt;
  logic [8:0]  m400_r, m400_nxt;
  logic [43:0] acc_r, acc_nxt;
  logic [31:0] aux_r, aux_nxt;
  logic [3:0]  mo_r, mo_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [4:0]  hrs_in_r, hrs_in_nxt;
  logic [5:0]  min_in_r, min_in_nxt;
  logic [5:0]  sec_in_r, sec_in_nxt;
  logic [1:0]  div_idx_r, div_idx_nxt;
  logic [5:0]  sec_o_r, sec_o_nxt;
  logic [5:0]  min_o_r, min_o_nxt;
  logic [4:0]  hrs_o_r, hrs_o_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [43:0] ms_r, ms_nxt;
  logic [7:0]  yo_r, yo_nxt;
  logic [3:0]  mo_out_r, mo_out_nxt;
  logic [4:0]  do_r, do_nxt;
  logic [4:0]  ho_r, ho_nxt;
  logic [5:0]  mio_r, mio_nxt;
  logic [5:0]  so_r, so_nxt;

  mac_op_t          mac_op;
  logic [MAC_W-1:0] mac_y;
  logic             in_ready;
  logic             load_out;
  logic             is_leap;
  logic [8:0]       diy;
  logic [4:0]       md;
  logic [9:0]       day_add;
  logic [11:0]      year_off;
  logic [8:0]       m400_inc;

  cec_mac u_mac (
    .op (mac_op),
    .y  (mac_y)
  );

  assign is_leap  = leap_f(m400_r);
  assign diy      = is_leap ? 9'd366 : 9'd365;
  assign md       = (mo_r == MONTH_FEB_IDX && is_leap) ? 5'd29 : month_len_f(mo_r);
  assign day_add  = {1'b0, days_before_f(month_r - 4'd1)}
                  + {9'd0, (month_r > 4'd2) && is_leap}
                  + {5'd0, day_r - 5'd1};
  assign year_off = year_r - BASE_YEAR;
  assign m400_inc = (m400_r == M400_LAST) ? 9'd0 : m400_r + 9'd1;

  assign in_ready     = (state_r == ST_IDLE) && (!out_valid_r || out_if.ready);
  assign in_if.ready  = in_ready;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    year_nxt      = year_r;
    tgt_nxt       = tgt_r;
    m400_nxt      = m400_r;
    acc_nxt       = acc_r;
    aux_nxt       = aux_r;
    mo_nxt        = mo_r;
    month_nxt     = month_r;
    day_nxt       = day_r;
    hrs_in_nxt    = hrs_in_r;
    min_in_nxt    = min_in_r;
    sec_in_nxt    = sec_in_r;
    div_idx_nxt   = div_idx_r;
    sec_o_nxt     = sec_o_r;
    min_o_nxt     = min_o_r;
    hrs_o_nxt     = hrs_o_r;
    ms_nxt        = ms_r;
    yo_nxt        = yo_r;
    mo_out_nxt    = mo_out_r;
    do_nxt        = do_r;
    ho_nxt        = ho_r;
    mio_nxt       = mio_r;
    so_nxt        = so_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    load_out      = 1'b0;
    mac_op        = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_if.valid && in_ready) begin
          op_nxt      = in_if.opcode;
          year_nxt    = EPOCH_YEAR;
          m400_nxt    = EPOCH_M400;
          tgt_nxt     = BASE_YEAR + {4'd0, in_if.year_in};
          mo_nxt      = 4'd0;
          div_idx_nxt = DIV_SEC;
          hrs_in_nxt  = in_if.hours_in;
          min_in_nxt  = in_if.minutes_in;
          sec_in_nxt  = in_if.seconds_in;
          // an out-of-range month is clamped; a day of zero becomes one
          if (in_if.month_in == 4'd0) begin
            month_nxt = 4'd1;
          end else if (in_if.month_in > MONTH_COUNT) begin
            month_nxt = MONTH_COUNT;
          end else begin
            month_nxt = in_if.month_in;
          end
          day_nxt = (in_if.day_in == 5'd0) ? 5'd1 : in_if.day_in;
          if (in_if.opcode == OP_SEC_TO_CAL) begin
            acc_nxt   = {12'd0, in_if.epoch_seconds};
            state_nxt = ST_DIVQ;
          end else begin
            acc_nxt   = '0;
            state_nxt = ST_YEAR0;
          end
        end
      end

      ST_YEAR0: begin
        if (year_r < tgt_r) begin
          mac_op.a = {25'd0, diy};
          mac_op.b = 32'd1;
          mac_op.c = acc_r;
          acc_nxt  = mac_y[43:0];
          year_nxt = year_r + 12'd1;
          m400_nxt = m400_inc;
        end else begin
          state_nxt = ST_MONTH0;
        end
      end

      ST_MONTH0: begin
        mac_op.a  = {24'd0, day_add};
        mac_op.b  = 32'd1;
        mac_op.c  = acc_r;
        acc_nxt   = mac_y[43:0];
        state_nxt = ST_HM;
      end

      ST_HM: begin
        mac_op.a  = {29'd0, hrs_in_r};
        mac_op.b  = SIXTY;
        mac_op.c  = {38'd0, min_in_r};
        aux_nxt   = mac_y[31:0];
        state_nxt = ST_HMS;
      end

      ST_HMS: begin
        mac_op.a  = {2'd0, aux_r};
        mac_op.b  = SIXTY;
        mac_op.c  = {38'd0, sec_in_r};
        aux_nxt   = mac_y[31:0];
        state_nxt = ST_SEC;
      end

      ST_SEC: begin
        mac_op.a  = acc_r[33:0];
        mac_op.b  = SEC_PER_DAY;
        mac_op.c  = {12'd0, aux_r};
        acc_nxt   = mac_y[43:0];
        state_nxt = ST_MS;
      end

      ST_MS: begin
        mac_op.a  = acc_r[33:0];
        mac_op.b  = MS_PER_SEC;
        acc_nxt   = mac_y[43:0];
        state_nxt = ST_DONE;
      end

      ST_DIVQ: begin
        // quotient by reciprocal multiply and shift
        mac_op.a = acc_r[33:0];
        if (div_idx_r == DIV_HOUR) begin
          mac_op.b = MAGIC_DIV24;
          aux_nxt  = 32'(mac_y >> SHIFT_DIV24);
        end else begin
          mac_op.b = MAGIC_DIV60;
          aux_nxt  = 32'(mac_y >> SHIFT_DIV60);
        end
        state_nxt = ST_DIVR;
      end

      ST_DIVR: begin
        mac_op.a   = {2'd0, aux_r};
        mac_op.b   = (div_idx_r == DIV_HOUR) ? TWENTY_FOUR : SIXTY;
        mac_op.c   = acc_r;
        mac_op.sub = 1'b1;
        acc_nxt    = {12'd0, aux_r};
        case (div_idx_r)
          DIV_SEC: begin
            sec_o_nxt   = mac_y[5:0];
            div_idx_nxt = DIV_MIN;
            state_nxt   = ST_DIVQ;
          end
          DIV_MIN: begin
            min_o_nxt   = mac_y[5:0];
            div_idx_nxt = DIV_HOUR;
            state_nxt   = ST_DIVQ;
          end
          default: begin
            hrs_o_nxt = mac_y[4:0];
            state_nxt = ST_YEAR1;
          end
        endcase
      end

      ST_YEAR1: begin
        if (acc_r < {35'd0, diy}) begin
          state_nxt = ST_MONTH1;
        end else begin
          mac_op.a   = {25'd0, diy};
          mac_op.b   = 32'd1;
          mac_op.c   = acc_r;
          mac_op.sub = 1'b1;
          acc_nxt    = mac_y[43:0];
          year_nxt   = year_r + 12'd1;
          m400_nxt   = m400_inc;
        end
      end

      ST_MONTH1: begin
        if (mo_r != MONTH_COUNT && acc_r >= {39'd0, md}) begin
          mac_op.a   = {29'd0, md};
          mac_op.b   = 32'd1;
          mac_op.c   = acc_r;
          mac_op.sub = 1'b1;
          acc_nxt    = mac_y[43:0];
          mo_nxt     = mo_r + 4'd1;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        load_out      = 1'b1;
        out_valid_nxt = 1'b1;
        if (op_r == OP_CAL_TO_MS) begin
          ms_nxt     = acc_r;
          yo_nxt     = '0;
          mo_out_nxt = '0;
          do_nxt     = '0;
          ho_nxt     = '0;
          mio_nxt    = '0;
          so_nxt     = '0;
        end else begin
          ms_nxt     = '0;
          yo_nxt     = year_off[7:0];
          mo_out_nxt = mo_r + 4'd1;
          do_nxt     = acc_r[4:0] + 5'd1;
          ho_nxt     = hrs_o_r;
          mio_nxt    = min_o_r;
          so_nxt     = sec_o_r;
        end
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    year_r    <= year_nxt;
    tgt_r     <= tgt_nxt;
    m400_r    <= m400_nxt;
    acc_r     <= acc_nxt;
    aux_r     <= aux_nxt;
    mo_r      <= mo_nxt;
    month_r   <= month_nxt;
    day_r     <= day_nxt;
    hrs_in_r  <= hrs_in_nxt;
    min_in_r  <= min_in_nxt;
    sec_in_r  <= sec_in_nxt;
    div_idx_r <= div_idx_nxt;
    sec_o_r   <= sec_o_nxt;
    min_o_r   <= min_o_nxt;
    hrs_o_r   <= hrs_o_nxt;
    ms_r      <= ms_nxt;
    yo_r      <= yo_nxt;
    mo_out_r  <= mo_out_nxt;
    do_r      <= do_nxt;
    ho_r      <= ho_nxt;
    mio_r     <= mio_nxt;
    so_r      <= so_nxt;
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.epoch_ms    = ms_r;
  assign out_if.year_out    = yo_r;
  assign out_if.month_out   = mo_out_r;
  assign out_if.day_out     = do_r;
  assign out_if.hours_out   = ho_r;
  assign out_if.minutes_out = mio_r;
  assign out_if.seconds_out = so_r;

  // a finished result never lands on one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> !out_valid_r)
    else $error("result loaded while output register still full");

  // a transaction taken with nothing new behind it empties the output
  a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_if.ready && !load_out) |=> !out_valid_r)
    else $error("output register not emptied after transaction");

  // 32-bit seconds never run the year loop past 2106
  a_year1_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_YEAR1) |-> (year_r <= LAST_YEAR))
    else $error("year loop ran past the 32-bit seconds range");

  // the year sum stops at the requested year
  a_year0_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_YEAR0) |-> (year_r <= tgt_r))
    else $error("year sum overshot the requested year");

endmodule

// ===== sim/calendar_epoch_converter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_epoch_converter_test
// Self-checking bench for the calendar / epoch converter. A directed table
// covers the field extremes, clamped months and days, leap and century years
// and the 32-bit seconds limit. Random requests follow: mostly well-formed
// dates and seconds near year and month edges, plus raw field noise. Every
// result is checked against an in-bench conversion, or against a typed value
// for the directed rows that give one. Both channels stall at random.
// ----------------------------------------------------------------------------
module calendar_epoch_converter_test import cec_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT  = 2_500_000;
  localparam int          DRAIN_CYCLES = 320;
  localparam int          RANDOM_ITEMS = 1250;
  localparam int unsigned MAX_REPORTS  = 40;

  typedef struct packed {
    logic        opcode;
    logic [31:0] epoch_seconds;
    logic [7:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
  } conv_req_t;

  typedef struct packed {
    logic [43:0] epoch_ms;
    logic [7:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
  } conv_res_t;

  typedef struct packed {
    conv_req_t req;
    logic      typed;
    conv_res_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  cec_in_if  req_ch ();
  cec_out_if res_ch ();

  calendar_epoch_converter DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (req_ch),
    .out_if (res_ch)
  );

  conv_res_t   due_results[$];
  int unsigned mismatch_count = 0;
  int unsigned result_count   = 0;
  int unsigned cycle_count    = 0;
  bit          steady         = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // calendar arithmetic
  // --------------------------------------------------------------------------
  function automatic bit is_leap(input int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
  endfunction

  function automatic int unsigned month_len(input int unsigned m, input bit leap_yr);
    case (m)
      2:           return leap_yr ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic longint unsigned days_to_year(input int unsigned y);
    longint unsigned days;
    days = 0;
    for (int unsigned yy = 1970; yy < y; yy++)
      days += is_leap(yy) ? 366 : 365;
    return days;
  endfunction

  function automatic longint unsigned days_to_month(input int unsigned y, input int unsigned m);
    longint unsigned days;
    days = 0;
    for (int unsigned k = 1; k < m; k++)
      days += month_len(k, is_leap(y));
    return days;
  endfunction

  function automatic conv_res_t convert_request(input conv_req_t r);
    conv_res_t       res;
    int unsigned     y, m, d;
    longint unsigned days, secs;
    res = '0;
    if (r.opcode == OP_CAL_TO_MS) begin
      y = 2000 + int'(r.year);
      m = r.month;
      if (m < 1) m = 1;
      if (m > 12) m = 12;
      d = (r.day == 0) ? 1 : int'(r.day);
      days = days_to_year(y) + days_to_month(y, m) + d - 1;
      secs = days * 86400 + longint'(r.hours) * 3600 + longint'(r.minutes) * 60
           + longint'(r.seconds);
      res.epoch_ms = 44'(secs * 1000);
    end else begin
      secs = r.epoch_seconds;
      res.seconds = 6'(secs % 60);
      secs = secs / 60;
      res.minutes = 6'(secs % 60);
      secs = secs / 60;
      res.hours = 5'(secs % 24);
      days = secs / 24;
      y = 1970;
      while (days >= (is_leap(y) ? 366 : 365)) begin
        days -= is_leap(y) ? 366 : 365;
        y++;
      end
      m = 1;
      while (m <= 12 && days >= month_len(m, is_leap(y))) begin
        days -= month_len(m, is_leap(y));
        m++;
      end
      // years before 2000 wrap in the 8-bit offset
      res.year  = 8'(y - 2000);
      res.month = 4'(m);
      res.day   = 5'(days + 1);
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  function automatic conv_req_t random_request();
    conv_req_t   r;
    int unsigned pick, yr_full, mo, dd, tod;
    longint      s;
    r.opcode        = 1'($urandom_range(0, 1));
    r.epoch_seconds = $urandom;
    r.year          = 8'($urandom);
    r.month         = 4'($urandom);
    r.day           = 5'($urandom);
    r.hours         = 5'($urandom);
    r.minutes       = 6'($urandom);
    r.seconds       = 6'($urandom);
    pick = $urandom_range(0, 99);
    if (r.opcode == OP_CAL_TO_MS) begin
      // raw field noise is left in for the remaining share
      if (pick < 85) begin
        r.month   = 4'($urandom_range(1, 12));
        r.day     = 5'($urandom_range(1, month_len(r.month, is_leap(2000 + int'(r.year)))));
        r.hours   = 5'($urandom_range(0, 23));
        r.minutes = 6'($urandom_range(0, 59));
        r.seconds = 6'($urandom_range(0, 59));
      end
    end else if (pick < 45) begin
      // land on or next to a month or year edge
      yr_full = $urandom_range(1970, 2106);
      mo  = $urandom_range(1, 12);
      dd  = $urandom_range(0, 1) ? 1 : month_len(mo, is_leap(yr_full));
      tod = $urandom_range(0, 1) ? 0 : 86399;
      s = longint'(days_to_year(yr_full) + days_to_month(yr_full, mo) + dd - 1) * 86400
        + tod + $urandom_range(0, 2) - 1;
      if (s >= 0 && s <= 64'hFFFF_FFFF) r.epoch_seconds = 32'(s);
    end else if (pick < 60) begin
      r.epoch_seconds = pick[0] ? $urandom_range(0, 200000)
                                : 32'hFFFF_FFFF - $urandom_range(0, 200000);
    end
    return r;
  endfunction

  function automatic plan_row_t cal_row(input int unsigned yr, input int unsigned mo,
                                        input int unsigned dy, input int unsigned hr,
                                        input int unsigned mi, input int unsigned se);
    plan_row_t row;
    row.req         = random_request();
    row.req.opcode  = OP_CAL_TO_MS;
    row.req.year    = 8'(yr);
    row.req.month   = 4'(mo);
    row.req.day     = 5'(dy);
    row.req.hours   = 5'(hr);
    row.req.minutes = 6'(mi);
    row.req.seconds = 6'(se);
    row.typed       = 1'b0;
    row.want        = '0;
    return row;
  endfunction

  function automatic plan_row_t sec_row(input logic [31:0] secs);
    plan_row_t row;
    row.req               = random_request();
    row.req.opcode        = OP_SEC_TO_CAL;
    row.req.epoch_seconds = secs;
    row.typed             = 1'b0;
    row.want              = '0;
    return row;
  endfunction

  function automatic plan_row_t typed_row(input plan_row_t row, input conv_res_t want);
    plan_row_t t;
    t       = row;
    t.typed = 1'b1;
    t.want  = want;
    return t;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    if (steady) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  task automatic send_request(input conv_req_t r, input conv_res_t want);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.opcode        <= r.opcode;
    req_ch.epoch_seconds <= r.epoch_seconds;
    req_ch.year_in       <= r.year;
    req_ch.month_in      <= r.month;
    req_ch.day_in        <= r.day;
    req_ch.hours_in      <= r.hours;
    req_ch.minutes_in    <= r.minutes;
    req_ch.seconds_in    <= r.seconds;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    due_results.push_back(want);
  endtask

  task automatic report_mismatch(input string field, input longint unsigned got,
                                 input longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: result %0d %s: got %0d, expected %0d",
               $time, result_count, field, got, want);
  endtask

  // --------------------------------------------------------------------------
  // result side
  // --------------------------------------------------------------------------
  initial begin : result_stall
    int unsigned stall;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      stall = rst_n ? pick_gap() : 1;
      res_ch.ready <= (stall == 0);
      if (stall > 1) repeat (stall - 1) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    conv_res_t got, want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.epoch_ms, res_ch.year_out, res_ch.month_out, res_ch.day_out,
              res_ch.hours_out, res_ch.minutes_out, res_ch.seconds_out};
      result_count++;
      if (due_results.size() == 0) begin
        report_mismatch("transaction with nothing pending", got.epoch_ms, 0);
      end else begin
        want = due_results.pop_front();
        if (got.epoch_ms !== want.epoch_ms) report_mismatch("epoch_ms", got.epoch_ms, want.epoch_ms);
        if (got.year !== want.year)         report_mismatch("year_out", got.year, want.year);
        if (got.month !== want.month)       report_mismatch("month_out", got.month, want.month);
        if (got.day !== want.day)           report_mismatch("day_out", got.day, want.day);
        if (got.hours !== want.hours)       report_mismatch("hours_out", got.hours, want.hours);
        if (got.minutes !== want.minutes)   report_mismatch("minutes_out", got.minutes, want.minutes);
        if (got.seconds !== want.seconds)   report_mismatch("seconds_out", got.seconds, want.seconds);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    plan_row_t plan[$];
    conv_req_t req;
    rst_n                <= 1'b0;
    req_ch.valid         <= 1'b0;
    req_ch.opcode        <= OP_CAL_TO_MS;
    req_ch.epoch_seconds <= '0;
    req_ch.year_in       <= '0;
    req_ch.month_in      <= '0;
    req_ch.day_in        <= '0;
    req_ch.hours_in      <= '0;
    req_ch.minutes_in    <= '0;
    req_ch.seconds_in    <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // 2000-01-01, also with month and day of zero clamped up
    plan.push_back(typed_row(cal_row(0, 1, 1, 0, 0, 0),
                             conv_res_t'{44'd946684800000, 8'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}));
    plan.push_back(typed_row(cal_row(0, 0, 0, 0, 0, 0),
                             conv_res_t'{44'd946684800000, 8'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}));
    // time fields at full width just add their weight
    plan.push_back(typed_row(cal_row(0, 1, 1, 31, 63, 63),
                             conv_res_t'{44'd946800243000, 8'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}));
    plan.push_back(cal_row(255, 12, 31, 23, 59, 59));
    plan.push_back(cal_row(255, 15, 31, 31, 63, 63));
    plan.push_back(cal_row(0, 2, 29, 12, 0, 0));
    plan.push_back(cal_row(0, 3, 1, 0, 0, 0));
    plan.push_back(cal_row(100, 3, 1, 0, 0, 0));
    plan.push_back(cal_row(1, 2, 31, 0, 0, 0));
    plan.push_back(cal_row(4, 12, 31, 23, 59, 59));
    plan.push_back(cal_row(106, 2, 7, 6, 28, 15));
    plan.push_back(typed_row(sec_row(32'd0),
                             conv_res_t'{44'd0, 8'd226, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}));
    plan.push_back(typed_row(sec_row(32'd946684800),
                             conv_res_t'{44'd0, 8'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}));
    plan.push_back(typed_row(sec_row(32'hFFFF_FFFF),
                             conv_res_t'{44'd0, 8'd106, 4'd2, 5'd7, 5'd6, 6'd28, 6'd15}));
    plan.push_back(sec_row(32'd946684799));
    plan.push_back(sec_row(32'd951782399));
    plan.push_back(sec_row(32'd951782400));
    plan.push_back(sec_row(32'd59));
    plan.push_back(sec_row(32'd86399));
    plan.push_back(sec_row(32'd68256000));
    plan.push_back(sec_row(32'd4107542399));
    plan.push_back(sec_row(32'd4107542400));
    plan.push_back(sec_row(32'h8000_0000));

    foreach (plan[i])
      send_request(plan[i].req, plan[i].typed ? plan[i].want : convert_request(plan[i].req));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // occasional stretches with no idling on either side
      if (i % 150 == 0) steady = ($urandom_range(0, 3) == 0);
      req = random_request();
      send_request(req, convert_request(req));
    end
    steady = 1'b0;
    req_ch.valid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
